// ===== rtl/blpht_pkg.sv =====
package blpht_pkg;

    localparam int unsigned KEY_W        = 64;
    localparam int unsigned VAL_W        = 64;
    localparam int unsigned BUCKET_SLOTS = 4;

    // Reflected CRC32C polynomial
    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;

    // Request types
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_FOUND       = 3'd0;
    localparam logic [2:0] ST_ABSENT      = 3'd1;
    localparam logic [2:0] ST_PROBE_LIMIT = 3'd2;
    localparam logic [2:0] ST_INSERTED    = 3'd3;
    localparam logic [2:0] ST_UPDATED     = 3'd4;
    localparam logic [2:0] ST_INSERT_FAIL = 3'd5;

    // One bucket: four keys or four values
    typedef logic [BUCKET_SLOTS-1:0][KEY_W-1:0] slot_row_t;

    // Outcome of comparing one bucket against the request key
    typedef struct packed {
        logic       hit;         // some slot resolves the request
        logic [1:0] slot;        // lowest such slot
        logic       slot_empty;  // that slot held no key
        logic       any_empty;   // bucket has at least one empty slot
    } cmp_res_t;

    // One byte of CRC32C, bit-serial inside (eight narrow steps)
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = (c >> 1) ^ (CRC32C_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== rtl/blpht_crc.sv =====
module blpht_crc
    import blpht_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    output logic             busy,
    output logic [31:0]      crc
);

    logic [KEY_W-1:0] key_reg;
    logic [31:0]      crc_reg;
    logic [2:0]       cnt_reg;
    logic             busy_reg;

    // Control: one key byte per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: least significant byte first
    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg <= key;
            crc_reg <= 32'd0;
        end else if (busy_reg) begin
            key_reg <= {8'd0, key_reg[KEY_W-1:8]};
            crc_reg <= crc32c_byte(crc_reg, key_reg[7:0]);
        end
    end

    assign busy = busy_reg;
    assign crc  = crc_reg;

endmodule

// ===== rtl/blpht_bucket_cmp.sv =====
module blpht_bucket_cmp
    import blpht_pkg::*;
(
    input  slot_row_t        row_keys,
    input  logic [KEY_W-1:0] key,
    input  logic             is_insert,
    output cmp_res_t         res
);

    logic [BUCKET_SLOTS-1:0] eq;
    logic [BUCKET_SLOTS-1:0] empty;
    logic [BUCKET_SLOTS-1:0] cand;

    // Per-slot compares
    always_comb begin
        for (int s = 0; s < BUCKET_SLOTS; s++) begin
            eq[s]    = (row_keys[s] == key);
            empty[s] = (row_keys[s] == '0);
            cand[s]  = eq[s] | (is_insert & empty[s]);
        end
    end

    // Lowest resolving slot
    always_comb begin
        res           = '0;
        res.hit       = |cand;
        res.any_empty = |empty;
        priority casez (cand)
            4'b???1: res.slot = 2'd0;
            4'b??10: res.slot = 2'd1;
            4'b?100: res.slot = 2'd2;
            4'b1000: res.slot = 2'd3;
            default: res.slot = 2'd0;
        endcase
        res.slot_empty = empty[res.slot];
    end

endmodule

// ===== rtl/blpht_table.sv =====
module blpht_table
    import blpht_pkg::*;
#(
    parameter int unsigned ROWS   = 16384,
    parameter int unsigned ROW_AW = 14
) (
    input  logic              aclk,
    input  logic [ROW_AW-1:0] rd_addr,
    output slot_row_t         rd_key,
    output slot_row_t         rd_val,
    input  logic              wr_en,
    input  logic [ROW_AW-1:0] wr_addr,
    input  slot_row_t         wr_key,
    input  slot_row_t         wr_val
);

    slot_row_t key_mem [ROWS];
    slot_row_t val_mem [ROWS];
    slot_row_t rd_key_reg;
    slot_row_t rd_val_reg;

    // One bucket row per access, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    assign rd_key = rd_key_reg;
    assign rd_val = rd_val_reg;

endmodule

// ===== rtl/bucketed_linear_probe_hash_table_top.sv =====
// Channel  | Handshake            | Beat contents
// ---------+----------------------+------------------------------------------------
// s_       | s_valid / s_ready    | req_type, key, value, tag, batch_end
// m_       | m_valid / m_ready    | status, found_value, tag_out, batch_end_out
// cfg_     | cfg_we (no wait)     | cfg_wdata = slots_log2
//
// Steps: an accepted request runs the byte-serial CRC32C over the eight key bytes,
// reads the home row, compares the probed buckets in turn, posts the result and
// goes back to idle. An insert of key zero goes straight from idle to posting
// its result. Requests are handled one at a time.
// Reset: a clearing pass writes zero into all SLOTS/4 bucket rows, one per cycle
// (16384 rows at the default size); s_ready stays low until it ends.
// Stalls: the result register holds one beat; the next request is accepted while it waits.
module bucketed_linear_probe_hash_table_top
    import blpht_pkg::*;
#(
    parameter int unsigned SLOTS = 65536   // power of two, 4 .. 16777216
) (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_we,
    input  logic [4:0]       cfg_wdata,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_req_type,
    input  logic [KEY_W-1:0] s_key,
    input  logic [VAL_W-1:0] s_value,
    input  logic [7:0]       s_tag,
    input  logic             s_batch_end,

    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_status,
    output logic [VAL_W-1:0] m_found_value,
    output logic [7:0]       m_tag_out,
    output logic             m_batch_end_out
);

    localparam int unsigned SLOT_AW = $clog2(SLOTS);
    localparam int unsigned ROW_AW  = (SLOT_AW > 2) ? SLOT_AW - 2 : 1;
    localparam int unsigned ROWS    = SLOTS / BUCKET_SLOTS;
    localparam int unsigned CW      = ROW_AW + 1;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

    // Sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_HASH = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [4:0]        slots_log2_reg;
    logic              req_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [7:0]        tag_reg;
    logic              batch_reg;
    logic [ROW_AW-1:0] row_reg, row_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [ROW_AW-1:0] clr_reg;
    logic [2:0]        status_reg, status_next;
    logic [VAL_W-1:0]  fval_reg, fval_next;
    logic              m_valid_reg;
    logic [2:0]        m_status_reg;
    logic [VAL_W-1:0]  m_fval_reg;
    logic [7:0]        m_tag_reg;
    logic              m_batch_reg;

    logic [4:0]        lg_eff;
    logic [CW-1:0]     nb;
    logic [ROW_AW-1:0] row_mask;
    logic [ROW_AW-1:0] home_row;
    logic [ROW_AW-1:0] row_inc;
    logic [CW-1:0]     cnt_inc;
    logic              accept;
    logic              out_free;
    logic              crc_busy;
    logic [31:0]       crc_val;
    logic [ROW_AW-1:0] rd_addr;
    slot_row_t         rd_key, rd_val;
    slot_row_t         wr_key, wr_val;
    slot_row_t         upd_key, upd_val;
    logic              wr_en;
    logic              ins_wr;
    logic [ROW_AW-1:0] wr_addr;
    cmp_res_t          cmp;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Effective table size: clamp to [4, SLOTS] slots
    always_comb begin
        lg_eff = slots_log2_reg;
        if (slots_log2_reg < 5'd2) begin
            lg_eff = 5'd2;
        end
        if (lg_eff > 5'(SLOT_AW)) begin
            lg_eff = 5'(SLOT_AW);
        end
    end

    assign nb       = CW'(1) << (lg_eff - 5'd2);
    assign row_mask = ROW_AW'(nb - CW'(1));
    assign home_row = crc_val[2 +: ROW_AW] & row_mask;
    assign row_inc  = (row_reg + ROW_AW'(1)) & row_mask;
    assign cnt_inc  = cnt_reg + CW'(1);

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_log2_reg <= 5'd16;
        end else if (cfg_we) begin
            slots_log2_reg <= cfg_wdata;
        end
    end

    // Shared hash unit
    blpht_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .key     (s_key),
        .busy    (crc_busy),
        .crc     (crc_val)
    );

    // Shared bucket compare unit
    blpht_bucket_cmp u_cmp (
        .row_keys  (rd_key),
        .key       (key_reg),
        .is_insert (req_reg == REQ_INSERT),
        .res       (cmp)
    );

    // Bucket storage; reading the next row ahead keeps one bucket per cycle
    assign rd_addr = (state_reg == S_CMP) ? row_inc : row_reg;

    always_comb begin
        upd_key           = rd_key;
        upd_val           = rd_val;
        upd_key[cmp.slot] = key_reg;
        upd_val[cmp.slot] = value_reg;
    end

    assign ins_wr  = (state_reg == S_CMP) && (req_reg == REQ_INSERT) && cmp.hit;
    assign wr_en   = (state_reg == S_CLR) || ins_wr;
    assign wr_addr = (state_reg == S_CLR) ? clr_reg : row_reg;
    assign wr_key  = (state_reg == S_CLR) ? '0 : upd_key;
    assign wr_val  = (state_reg == S_CLR) ? '0 : upd_val;

    blpht_table #(
        .ROWS   (ROWS),
        .ROW_AW (ROW_AW)
    ) u_table (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_val  (rd_val),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_val  (wr_val)
    );

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        row_next    = row_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        fval_next   = fval_reg;
        unique case (state_reg)
            S_CLR: begin
                if (clr_reg == LAST_ROW) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if ((s_req_type == REQ_INSERT) && (s_key == '0)) begin
                        status_next = ST_INSERT_FAIL;
                        fval_next   = '0;
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (!crc_busy) begin
                    row_next   = home_row;
                    cnt_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                fval_next = '0;
                if (cmp.hit) begin
                    state_next = S_OUT;
                    if (req_reg == REQ_INSERT) begin
                        status_next = cmp.slot_empty ? ST_INSERTED : ST_UPDATED;
                    end else begin
                        status_next = ST_FOUND;
                        fval_next   = rd_val[cmp.slot];
                    end
                end else if (cnt_inc == nb) begin
                    state_next  = S_OUT;
                    status_next = (req_reg == REQ_INSERT) ? ST_INSERT_FAIL
                                                          : ST_PROBE_LIMIT;
                end else if ((req_reg == REQ_LOOKUP) && cmp.any_empty) begin
                    state_next  = S_OUT;
                    status_next = ST_ABSENT;
                end else begin
                    row_next = row_inc;
                    cnt_next = cnt_inc;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLR) begin
                clr_reg <= clr_reg + ROW_AW'(1);
            end
        end
    end

    // Request and probe registers
    always_ff @(posedge aclk) begin
        row_reg    <= row_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        fval_reg   <= fval_next;
        if (accept) begin
            req_reg   <= s_req_type;
            key_reg   <= s_key;
            value_reg <= s_value;
            tag_reg   <= s_tag;
            batch_reg <= s_batch_end;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_OUT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_OUT) && out_free) begin
            m_status_reg <= status_reg;
            m_fval_reg   <= fval_reg;
            m_tag_reg    <= tag_reg;
            m_batch_reg  <= batch_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_found_value   = m_fval_reg;
    assign m_tag_out       = m_tag_reg;
    assign m_batch_end_out = m_batch_reg;

`ifndef SYNTHESIS
    // Table writes only from the clearing pass or a resolved insert
    a_wr_source: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_CLR || state_reg == S_CMP))
        else $error("table write outside clear or compare");

    // Probe count stays below the bucket count
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> (cnt_reg < nb))
        else $error("probe count past table size");

    // Probed row stays inside the active table
    a_row_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> ((row_reg & ~row_mask) == '0))
        else $error("row index outside active table");

    // Hash unit starts on every accepted beat
    a_hash_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> crc_busy)
        else $error("hash unit not started");

    // A new result beat only comes from the output state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result posted outside output state");
`endif

endmodule
